// ===== rtl/dsbn_pkg.sv =====
// ----------------------------------------------------------------------------
// dsbn_pkg
// Shared constants and types of the dual sample to byte normalizer.
// ----------------------------------------------------------------------------
package dsbn_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int BYTE_BITS       = 8;
  localparam int QUO_BITS        = BYTE_BITS + 1;
  localparam int CMD_BITS        = 2;

  localparam logic [CMD_BITS-1:0] CMD_MEASURE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_CONVERT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd2;

  localparam logic [BYTE_BITS-1:0] FULL_SCALE = 8'd255;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [BYTE_BITS-1:0] value;
  } lane_status_t;

endpackage

// ===== rtl/dsbn_lane.sv =====
// ----------------------------------------------------------------------------
// dsbn_lane
// One normalizing lane: restoring division of |s|*255 by the matching extreme,
// one quotient bit per cycle, saturated at 255.
// ----------------------------------------------------------------------------
module dsbn_lane
  import dsbn_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   take,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] low_ext,
  input  logic [SAMPLE_BITS-1:0] high_ext,
  output lane_status_t           status
);

  localparam int NUM_BITS = SAMPLE_BITS + BYTE_BITS;
  localparam int CNT_BITS = $clog2(QUO_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state;
  logic [CNT_BITS-1:0]    count;
  logic [NUM_BITS-1:0]    rem;
  logic [NUM_BITS-1:0]    div;
  logic [QUO_BITS-1:0]    quo;
  logic                   zero;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] den_src;
  logic [SAMPLE_BITS-1:0] den;
  logic [NUM_BITS-1:0]    mag_ext;
  logic [NUM_BITS-1:0]    num;
  logic                   fits;
  logic [NUM_BITS-1:0]    diff;

  assign mag     = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign den_src = sample[SAMPLE_BITS-1] ? low_ext : high_ext;
  assign den     = den_src[SAMPLE_BITS-1] ? (~den_src + 1'b1) : den_src;
  assign mag_ext = {{BYTE_BITS{1'b0}}, mag};
  assign num     = (mag_ext << BYTE_BITS) - mag_ext;
  assign fits    = rem >= div;
  assign diff    = rem - div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            count <= CNT_BITS'(QUO_BITS - 1);
          end
        end
        ST_RUN: begin
          if (count == '0) begin
            state <= ST_DONE;
          end else begin
            count <= count - 1'b1;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (start) begin
        rem  <= num;
        div  <= {den, {BYTE_BITS{1'b0}}};
        quo  <= '0;
        zero <= (den == '0);
      end
    end else if (state == ST_RUN) begin
      if (fits) begin
        rem <= diff;
      end
      quo <= {quo[QUO_BITS-2:0], fits};
      div <= div >> 1;
    end
  end

  always_comb begin
    status.busy = (state != ST_IDLE);
    status.done = (state == ST_DONE);
    if (zero) begin
      status.value = '0;
    end else if (quo[QUO_BITS-1]) begin
      status.value = FULL_SCALE;
    end else begin
      status.value = quo[BYTE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/dsbn_merge.sv =====
// ----------------------------------------------------------------------------
// dsbn_merge
// Output stage: joins the two lane results into one request and holds it
// until the receiver takes it.
// ----------------------------------------------------------------------------
module dsbn_merge
  import dsbn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  lane_status_t         lane_a,
  input  lane_status_t         lane_b,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_BITS-1:0] byte_a,
  output logic [BYTE_BITS-1:0] byte_b
);

  assign take = lane_a.done && lane_b.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_a <= lane_a.value;
      byte_b <= lane_b.value;
    end
  end

endmodule

// ===== rtl/dual_sample_to_byte_normalizer.sv =====
// ----------------------------------------------------------------------------
// dual_sample_to_byte_normalizer
// Tracks the low and high extremes of signed sample pairs and maps a pair to
// two bytes scaled against those extremes.
//
// Input channel: command, sample_a, sample_b under in_valid / in_ready.
// Measure widens the extremes, clear zeroes them; neither gives a result.
// Convert starts both lanes at once; each lane runs a restoring divider of
// |s|*255 by the matching extreme, one quotient bit per cycle, so a convert
// request leaves in_ready low until both lanes pass their bytes to the output
// register, where they appear on out_valid / out_ready.
// Measure and clear requests are taken one per cycle while no convert runs.
// A zero extreme gives byte 0; a quotient above 255 gives 255.
// When the receiver stalls, the result holds in the output register; a later
// convert holds its bytes in the lanes behind it and the input waits until
// the output register frees.
// Reset zeroes both extremes and empties the lanes and the output register.
// ----------------------------------------------------------------------------
module dual_sample_to_byte_normalizer
  import dsbn_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_BITS-1:0]    command,
  input  logic [SAMPLE_BITS-1:0] sample_a,
  input  logic [SAMPLE_BITS-1:0] sample_b,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_BITS-1:0]   byte_a,
  output logic [BYTE_BITS-1:0]   byte_b
);

  logic signed [SAMPLE_BITS-1:0] low_extreme;
  logic signed [SAMPLE_BITS-1:0] high_extreme;
  logic signed [SAMPLE_BITS-1:0] low_extreme_next;
  logic signed [SAMPLE_BITS-1:0] high_extreme_next;
  logic signed [SAMPLE_BITS-1:0] low_ab;
  logic signed [SAMPLE_BITS-1:0] high_ab;
  logic signed [SAMPLE_BITS-1:0] sa;
  logic signed [SAMPLE_BITS-1:0] sb;

  logic         accept;
  logic         start;
  logic         take;
  lane_status_t lane_a;
  lane_status_t lane_b;

  assign in_ready = !lane_a.busy && !lane_b.busy;
  assign accept   = in_valid && in_ready;
  assign start    = accept && (command == CMD_CONVERT);

  assign sa      = $signed(sample_a);
  assign sb      = $signed(sample_b);
  assign low_ab  = (sa < sb) ? sa : sb;
  assign high_ab = (sa > sb) ? sa : sb;

  always_comb begin
    low_extreme_next  = low_extreme;
    high_extreme_next = high_extreme;
    if (accept) begin
      unique case (command)
        CMD_MEASURE: begin
          if (low_ab < low_extreme) begin
            low_extreme_next = low_ab;
          end
          if (high_ab > high_extreme) begin
            high_extreme_next = high_ab;
          end
        end
        CMD_CLEAR: begin
          low_extreme_next  = '0;
          high_extreme_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_extreme  <= '0;
      high_extreme <= '0;
    end else begin
      low_extreme  <= low_extreme_next;
      high_extreme <= high_extreme_next;
    end
  end

  dsbn_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_a (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .take     (take),
    .sample   (sample_a),
    .low_ext  (low_extreme),
    .high_ext (high_extreme),
    .status   (lane_a)
  );

  dsbn_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_b (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .take     (take),
    .sample   (sample_b),
    .low_ext  (low_extreme),
    .high_ext (high_extreme),
    .status   (lane_b)
  );

  dsbn_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_a    (lane_a),
    .lane_b    (lane_b),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte_a    (byte_a),
    .byte_b    (byte_b)
  );

endmodule

// ===== rtl/dsbn_checker.sv =====
// ----------------------------------------------------------------------------
// dsbn_checker
// Port-level checks of the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module dsbn_checker
  import dsbn_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [CMD_BITS-1:0]  command,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [BYTE_BITS-1:0] byte_a,
  input logic [BYTE_BITS-1:0] byte_b
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_a) && $stable(byte_b))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_convert_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_CONVERT |=> !in_ready)
    else $error("convert request did not occupy the lanes");

  a_other_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command != CMD_CONVERT |=> in_ready)
    else $error("measure or clear request blocked the input");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_CONVERT && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind dual_sample_to_byte_normalizer dsbn_checker u_dsbn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .command   (command),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .byte_a    (byte_a),
  .byte_b    (byte_b)
);
